FILE: sv/seth_pkg.sv
// Shared types, register codes and threshold arithmetic for the edge trigger.
`default_nettype none
package seth_pkg;

  // Default sample width and the widest width the arithmetic supports
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_MAX = 16;

  // Register file layout
  localparam int          LEVEL_BITS = 10;
  localparam logic [9:0]  LEVEL_RST  = 10'd512;
  localparam logic        RISING_RST = 1'b1;
  localparam logic        ARMED_RST  = 1'b1;
  localparam int          ADDR_BITS  = 4;
  localparam int          DATA_BITS  = 32;

  // Divide-by-ten reciprocal: floor(2^20 / 10), valid for 20-bit dividends
  localparam int          DIV_BITS   = 20;
  localparam logic [16:0] RECIP10    = 17'd104857;

  typedef enum logic [1:0] {
    REG_LEVEL  = 2'd0,
    REG_RISING = 2'd1,
    REG_ARMED  = 2'd2
  } reg_idx_t;

  // Mode bits handed from the register file to the trigger core
  typedef struct packed {
    logic rising;
    logic armed;
  } mode_t;

  // floor(x / 10) by reciprocal multiply, one correction step
  function automatic logic [19:0] div10(input logic [19:0] x);
    logic [36:0] prod;
    logic [19:0] q;
    logic [19:0] r;
    prod = 37'(x) * 37'(RECIP10);
    q    = 20'(prod[36:20]);
    r    = x - 20'(q * 20'd10);
    if (r >= 20'd10) begin
      q = q + 20'd1;
    end
    return q;
  endfunction

  // High threshold: floor(level * 11 / 10)
  function automatic logic [19:0] thr_hi(input logic [15:0] lvl);
    return div10(20'(lvl) * 20'd11);
  endfunction

  // Low threshold: floor(level * 9 / 10)
  function automatic logic [19:0] thr_lo(input logic [15:0] lvl);
    return div10(20'(lvl) * 20'd9);
  endfunction

endpackage
`default_nettype wire

FILE: sv/seth_cfg.sv
// APB register file with threshold precompute on level writes.
`default_nettype none
module seth_cfg
  import seth_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic      [DATA_BITS-1:0]   prdata,
  output logic                        pready,
  output logic      [SAMPLE_BITS-1:0] level,
  output logic      [SAMPLE_BITS:0]   hi_level,
  output logic      [SAMPLE_BITS-1:0] lo_level,
  output mode_t                       mode
);

  // Level bits that survive both the register mask and the sample mask
  localparam int LMIN = (SAMPLE_BITS < LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

  logic [LEVEL_BITS-1:0]  level_r;
  logic                   rising_r;
  logic                   armed_r;
  logic [SAMPLE_BITS:0]   hi_level_r;
  logic [SAMPLE_BITS-1:0] lo_level_r;
  logic                   wr_en;
  reg_idx_t               idx;
  logic [SAMPLE_BITS-1:0] wr_lvl;
  logic [SAMPLE_BITS-1:0] rst_lvl;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign idx     = reg_idx_t'(paddr[3:2]);
  assign wr_lvl  = SAMPLE_BITS'(pwdata[LMIN-1:0]);
  assign rst_lvl = SAMPLE_BITS'(LEVEL_RST[LMIN-1:0]);

  // Register writes; thresholds follow the level so a rearm only copies them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= LEVEL_RST;
      rising_r   <= RISING_RST;
      armed_r    <= ARMED_RST;
      hi_level_r <= (SAMPLE_BITS+1)'(thr_hi(16'(rst_lvl)));
      lo_level_r <= SAMPLE_BITS'(thr_lo(16'(rst_lvl)));
    end else if (wr_en) begin
      case (idx)
        REG_LEVEL: begin
          level_r    <= pwdata[LEVEL_BITS-1:0];
          hi_level_r <= (SAMPLE_BITS+1)'(thr_hi(16'(wr_lvl)));
          lo_level_r <= SAMPLE_BITS'(thr_lo(16'(wr_lvl)));
        end
        REG_RISING: rising_r <= pwdata[0];
        REG_ARMED:  armed_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_LEVEL:  prdata = DATA_BITS'(level_r);
      REG_RISING: prdata = DATA_BITS'(rising_r);
      REG_ARMED:  prdata = DATA_BITS'(armed_r);
      default:    prdata = '0;
    endcase
  end

  assign level       = SAMPLE_BITS'(level_r[LMIN-1:0]);
  assign hi_level    = hi_level_r;
  assign lo_level    = lo_level_r;
  assign mode.rising = rising_r;
  assign mode.armed  = armed_r;

endmodule
`default_nettype wire

FILE: sv/seth_core.sv
// Trigger state update and two-entry result buffer.
`default_nettype none
module seth_core
  import seth_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_operation,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_code,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_triggered,
  output logic                        out_high_seen,
  output logic                        out_low_seen,
  input  wire logic [SAMPLE_BITS-1:0] level,
  input  wire logic [SAMPLE_BITS:0]   hi_level,
  input  wire logic [SAMPLE_BITS-1:0] lo_level,
  input  wire mode_t                  mode
);

  // Trigger state
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                   sh_r, sh_nxt;
  logic                   sl_r, sl_nxt;
  logic                   latch_r, latch_nxt;
  logic [SAMPLE_BITS:0]   hth_r, hth_nxt;
  logic [SAMPLE_BITS-1:0] lth_r, lth_nxt;
  logic                   hit;

  // Result buffer: head and skid entries, {triggered, high, low}
  logic [2:0] out_r, skid_r, res;
  logic       out_valid_r, skid_valid_r;

  logic                   push, pop;
  logic [SAMPLE_BITS-1:0] s;
  logic                   s_ge_hth, s_le_lth, up, down, ge_lvl, le_lvl;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid & in_ready;
  assign pop      = out_valid_r & out_ready;
  assign s        = in_sample_code;

  // Comparisons against stored state
  assign s_ge_hth = {1'b0, s} >= hth_r;
  assign s_le_lth = s <= lth_r;
  assign up       = s > prev_r;
  assign down     = s < prev_r;
  assign ge_lvl   = s >= level;
  assign le_lvl   = s <= level;

  // Next state and hit for one item
  always_comb begin
    prev_nxt  = prev_r;
    sh_nxt    = sh_r;
    sl_nxt    = sl_r;
    latch_nxt = latch_r;
    hth_nxt   = hth_r;
    lth_nxt   = lth_r;
    hit       = 1'b0;
    if (in_operation) begin
      // rearm
      prev_nxt  = s;
      sh_nxt    = 1'b0;
      sl_nxt    = 1'b0;
      latch_nxt = 1'b0;
      hth_nxt   = hi_level;
      lth_nxt   = lo_level;
    end else if (mode.armed) begin
      if (latch_r) begin
        hit = 1'b1;
      end else begin
        prev_nxt = s;
        if (up || down) begin
          if (mode.rising) begin
            if (!sh_r) begin
              sh_nxt = s_ge_hth;
            end else if (!sl_r) begin
              sl_nxt = s_le_lth;
            end else if (up && ge_lvl) begin
              latch_nxt = 1'b1;
              hit       = 1'b1;
            end
          end else begin
            if (!sl_r) begin
              sl_nxt = s_le_lth;
            end else if (sh_r || s_ge_hth) begin
              // falling arm completes; this sample may fire at once
              sh_nxt = 1'b1;
              if (down && le_lvl) begin
                latch_nxt = 1'b1;
                hit       = 1'b1;
              end
            end
          end
        end
      end
    end else begin
      // plain edge check
      prev_nxt = s;
      if ((mode.rising && up && ge_lvl) || (!mode.rising && down && le_lvl)) begin
        latch_nxt = 1'b1;
        hit       = 1'b1;
      end
    end
  end

  assign res = {hit, sh_nxt, sl_nxt};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      sh_r    <= 1'b0;
      sl_r    <= 1'b0;
      latch_r <= 1'b0;
      hth_r   <= '0;
      lth_r   <= '0;
    end else if (push) begin
      prev_r  <= prev_nxt;
      sh_r    <= sh_nxt;
      sl_r    <= sl_nxt;
      latch_r <= latch_nxt;
      hth_r   <= hth_nxt;
      lth_r   <= lth_nxt;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r  <= 1'b1;
      end
    end
  end

  // Result buffer data
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_triggered = out_r[2];
  assign out_high_seen = out_r[1];
  assign out_low_seen  = out_r[0];

`ifndef ASSERT_OFF
  // Skid entry is only ever occupied behind a valid head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without head entry");

  // A waiting result is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result lost");

  // Rearm clears flags and latch
  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_operation) |=> (!latch_r && !sh_r && !sl_r))
    else $error("rearm did not clear trigger state");

  // Latched armed trigger freezes the previous sample
  a_latch_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !in_operation && mode.armed && latch_r) |=> ($stable(prev_r) && latch_r))
    else $error("latched trigger changed state");
`endif

endmodule
`default_nettype wire

FILE: sv/scope_edge_trigger_hysteresis.sv
// Top level of the oscilloscope edge trigger with hysteresis arming.
//
//   channel | direction | handshake              | beat contents
//   --------+-----------+------------------------+--------------------------------
//   in_     | input     | in_valid / in_ready    | operation, sample_code
//   out_    | output    | out_valid / out_ready  | triggered, high_seen, low_seen
//   apb     | input     | psel, penable, pready  | trigger_level, rising_edge, armed_mode
//
// One beat in per cycle while in_ready is high; its result is registered into the result buffer.
// The result comes from the single state-update stage in front of the result register.
// A two-entry result buffer keeps input accepted while one result waits downstream.
// rst_n is synchronous active low; registers return to level 512, rising, armed.
// Thresholds are computed when the level is written, so a rearm only copies them.
`default_nettype none
module scope_edge_trigger_hysteresis
  import seth_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_operation,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_code,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_triggered,
  output logic                        out_high_seen,
  output logic                        out_low_seen,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic      [DATA_BITS-1:0]   prdata,
  output logic                        pready
);

  logic [SAMPLE_BITS-1:0] level;
  logic [SAMPLE_BITS:0]   hi_level;
  logic [SAMPLE_BITS-1:0] lo_level;
  mode_t                  mode;

  seth_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .level    (level),
    .hi_level (hi_level),
    .lo_level (lo_level),
    .mode     (mode)
  );

  seth_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_sample_code (in_sample_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_triggered  (out_triggered),
    .out_high_seen  (out_high_seen),
    .out_low_seen   (out_low_seen),
    .level          (level),
    .hi_level       (hi_level),
    .lo_level       (lo_level),
    .mode           (mode)
  );

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the edge trigger: queue-fed driver, checking monitor and APB setup.
module tb;
  import seth_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int CODE_MAX      = (1 << SB) - 1;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_AT_BEAT  = 400;
  localparam int HOLD_CYCLES   = 250;
  localparam int PHASE_BEATS   = 160;
  localparam int NUM_PHASES    = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_REARM    = 1'b1;
  localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED = 4'd12;

  typedef struct packed {
    logic          op;
    logic [SB-1:0] code;
  } sample_beat_t;

  typedef struct packed {
    logic triggered;
    logic high_seen;
    logic low_seen;
  } verdict_t;

  // Per-phase trigger settings; -1 picks a random value
  int phase_level  [NUM_PHASES] = '{512, 0, 1023, 300, 1023, 0, -1, -1, -1};
  int phase_rising [NUM_PHASES] = '{1, 1, 0, 0, 1, 0, -1, -1, -1};
  int phase_armed  [NUM_PHASES] = '{1, 1, 1, 1, 0, 0, -1, -1, -1};

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [SB-1:0]        in_sample_code;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_triggered;
  logic                 out_high_seen;
  logic                 out_low_seen;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Trigger settings as the bench believes the block holds them
  logic [SB-1:0] cfg_level;
  logic          cfg_rising;
  logic          cfg_armed;

  // Mirror of the trigger state
  logic [SB-1:0] prev_code;
  logic          seen_hi;
  logic          seen_lo;
  logic          latched;
  logic [SB:0]   hi_mark;
  logic [SB-1:0] lo_mark;

  sample_beat_t sample_q[$];
  verdict_t     verdict_q[$];
  sample_beat_t cur_beat;
  verdict_t     new_verdict;
  verdict_t     want;

  logic steady;
  int   gap_left;
  int   stall_left;
  int   hold_left;
  int   beats_queued;
  int   beats_taken;
  int   beats_checked;
  int   rearms;
  int   fires;
  int   errors;
  int   cycles;

  always #5 clk = ~clk;

  scope_edge_trigger_hysteresis #(
    .SAMPLE_BITS(SB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_sample_code(in_sample_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_triggered (out_triggered),
    .out_high_seen (out_high_seen),
    .out_low_seen  (out_low_seen),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the trigger mirror by one beat and return the result it produces
  task trigger_step(input sample_beat_t b, output verdict_t v);
    logic [SB-1:0] s;
    logic [SB-1:0] last;
    logic          hit;
    s   = b.code;
    hit = 1'b0;
    if (b.op == OP_REARM) begin
      latched   = 1'b0;
      prev_code = s;
      seen_hi   = 1'b0;
      seen_lo   = 1'b0;
      hi_mark   = (SB+1)'((int'(cfg_level) * 11) / 10);
      lo_mark   = SB'((int'(cfg_level) * 9) / 10);
    end else if (cfg_armed && latched) begin
      // held until the next rearm; nothing moves, not even the last sample
      hit = 1'b1;
    end else begin
      last      = prev_code;
      prev_code = s;
      if (s == last) begin
        hit = 1'b0;
      end else if (!cfg_armed) begin
        if (cfg_rising ? (s > last && s >= cfg_level) : (s < last && s <= cfg_level)) begin
          latched = 1'b1;
          hit     = 1'b1;
        end
      end else if (cfg_rising) begin
        // high first, then low, then a rise to the level
        if (!seen_hi) begin
          seen_hi = ({1'b0, s} >= hi_mark);
        end else if (!seen_lo) begin
          seen_lo = (s <= lo_mark);
        end else if (s > last && s >= cfg_level) begin
          latched = 1'b1;
          hit     = 1'b1;
        end
      end else begin
        // low first, then high; the beat that sees high may fire at once
        if (!seen_lo) begin
          seen_lo = (s <= lo_mark);
        end else begin
          if (!seen_hi && {1'b0, s} >= hi_mark) seen_hi = 1'b1;
          if (seen_hi && s < last && s <= cfg_level) begin
            latched = 1'b1;
            hit     = 1'b1;
          end
        end
      end
    end
    v.triggered = hit;
    v.high_seen = seen_hi;
    v.low_seen  = seen_lo;
  endtask

  // Input driver: predicts on acceptance, then offers the next queued beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        trigger_step(cur_beat, new_verdict);
        verdict_q.push_back(new_verdict);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          cur_beat = sample_q.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= cur_beat.op;
          in_sample_code <= cur_beat.code;
          gap_left = steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_bit(input string field, input logic exp_v, input logic got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0b got %0b", $time, field, exp_v, got_v);
      errors++;
    end
  endtask

  // Result monitor: checks each beat, then decides on back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %0b%0b%0b", $time,
                   out_triggered, out_high_seen, out_low_seen);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (want.triggered) fires++;
          check_bit("triggered", want.triggered, out_triggered);
          check_bit("high_seen", want.high_seen, out_high_seen);
          check_bit("low_seen", want.low_seen, out_low_seen);
        end
        beats_checked++;
        if (beats_checked == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // long hold-off so the block backs up into its input
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("scope_edge_trigger_hysteresis: mismatch");
      $finish;
    end
  end

  task automatic offer(input logic op, input int code);
    sample_beat_t b;
    b.op   = op;
    b.code = SB'(code);
    sample_q.push_back(b);
    beats_queued++;
    if (op == OP_REARM) rearms++;
  endtask

  // Wait until every beat is taken and every result checked, then let the pipe settle
  task automatic drain();
    while (beats_taken != beats_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx_t'(addr[ADDR_BITS-1:2]))
      REG_LEVEL:  cfg_level  = data[LEVEL_BITS-1:0];
      REG_RISING: cfg_rising = data[0];
      REG_ARMED:  cfg_armed  = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [ADDR_BITS-1:0] reg_addr(input reg_idx_t r);
    return ADDR_BITS'(r) << 2;
  endfunction

  // Occasionally set bits above the register width; the block must drop them
  function automatic logic [DATA_BITS-1:0] junk_above(input int bits);
    logic [DATA_BITS-1:0] j;
    j = $urandom();
    return ($urandom_range(0, 2) == 0) ? (j << bits) : '0;
  endfunction

  task automatic write_reg(input reg_idx_t r, input int bits, input int value);
    apb_write(reg_addr(r), junk_above(bits) | DATA_BITS'(value));
  endtask

  // Rearm followed by a triangle sweep around the level, so arming gets exercised
  task automatic queue_wave(input int lvl, inout int n);
    int top;
    int bot;
    int v;
    int dir;
    int step;
    int len;
    top = (lvl * 11) / 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40));
    bot = (lvl * 9) / 10 - (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40));
    if (top > CODE_MAX) top = CODE_MAX;
    if (bot < 0) bot = 0;
    if (top <= bot) top = bot + 1;
    v    = $urandom_range(bot, top);
    dir  = $urandom_range(0, 1) ? 1 : -1;
    step = $urandom_range(1, 48);
    len  = $urandom_range(12, 48);
    offer(OP_REARM, v);
    repeat (len) begin
      if ($urandom_range(0, 9) != 0) v += dir * $urandom_range(1, step);
      if (v >= top) begin
        v   = top;
        dir = -1;
      end
      if (v <= bot) begin
        v   = bot;
        dir = 1;
      end
      offer(OP_SAMPLE, v);
    end
    n += len + 1;
  endtask

  // Unstructured beats: random codes with the odd rearm
  task automatic queue_noise(inout int n);
    int k;
    k = $urandom_range(1, 6);
    repeat (k) begin
      offer(($urandom_range(0, 7) == 0) ? OP_REARM : OP_SAMPLE, $urandom_range(0, CODE_MAX));
    end
    n += k;
  endtask

  initial begin
    int n;
    int lvl;
    int rise;
    int arm;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_SAMPLE;
    in_sample_code = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady         = 1'b0;
    cfg_level      = LEVEL_RST;
    cfg_rising     = RISING_RST;
    cfg_armed      = ARMED_RST;
    prev_code      = '0;
    seen_hi        = 1'b0;
    seen_lo        = 1'b0;
    latched        = 1'b0;
    hi_mark        = '0;
    lo_mark        = '0;
    gap_left       = 0;
    stall_left     = 0;
    hold_left      = 0;
    beats_queued   = 0;
    beats_taken    = 0;
    beats_checked  = 0;
    rearms         = 0;
    fires          = 0;
    errors         = 0;
    cycles         = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, zero thresholds: repeat, arm, fire, then hold while latched
    offer(OP_SAMPLE, 0);
    offer(OP_SAMPLE, CODE_MAX);
    offer(OP_SAMPLE, 0);
    offer(OP_SAMPLE, 600);
    offer(OP_SAMPLE, 100);
    // Thresholds exactly at 563 and 460, fire exactly at the level
    offer(OP_REARM, 300);
    offer(OP_SAMPLE, 562);
    offer(OP_SAMPLE, 563);
    offer(OP_SAMPLE, 461);
    offer(OP_SAMPLE, 460);
    offer(OP_SAMPLE, 460);
    offer(OP_SAMPLE, 511);
    offer(OP_SAMPLE, 512);
    offer(OP_REARM, CODE_MAX);
    drain();

    // Falling edge: low seen, then stop short of the high threshold
    write_reg(REG_RISING, 1, 0);
    offer(OP_REARM, 512);
    offer(OP_SAMPLE, 461);
    offer(OP_SAMPLE, 460);
    offer(OP_SAMPLE, 520);
    drain();

    // A plain-mode beat lifts the last sample, so the beat that sees high fires at once
    write_reg(REG_ARMED, 1, 0);
    offer(OP_SAMPLE, 700);
    drain();
    write_reg(REG_ARMED, 1, 1);
    write_reg(REG_LEVEL, LEVEL_BITS, CODE_MAX);
    offer(OP_SAMPLE, 600);
    offer(OP_SAMPLE, CODE_MAX);
    drain();

    // A plain-mode fire latches, and armed mode then holds it
    write_reg(REG_ARMED, 1, 0);
    offer(OP_REARM, 900);
    offer(OP_SAMPLE, 100);
    drain();
    write_reg(REG_ARMED, 1, 1);
    offer(OP_SAMPLE, 50);
    offer(OP_SAMPLE, 50);
    drain();

    // Random phases, one trigger setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lvl  = (phase_level[ph] < 0) ? $urandom_range(0, CODE_MAX) : phase_level[ph];
      rise = (phase_rising[ph] < 0) ? $urandom_range(0, 1) : phase_rising[ph];
      arm  = (phase_armed[ph] < 0) ? $urandom_range(0, 1) : phase_armed[ph];
      steady <= (ph % 4 == 3);
      write_reg(REG_LEVEL, LEVEL_BITS, lvl);
      write_reg(REG_RISING, 1, rise);
      write_reg(REG_ARMED, 1, arm);
      if (ph == 4) apb_write(ADDR_UNMAPPED, $urandom());
      n = 0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(0, 9) < 8) queue_wave(lvl, n);
        else queue_noise(n);
      end
      drain();
    end

    $display("Ran %0d beats (%0d rearms, %0d fires) through %0d trigger settings.",
             beats_checked, rearms, fires, NUM_PHASES + 4);
    $display("Both edge directions, armed and plain modes, level extremes and a long hold-off.");
    if (errors == 0) begin
      $display("scope_edge_trigger_hysteresis: match");
    end else begin
      $display("scope_edge_trigger_hysteresis: mismatch");
    end
    $finish;
  end

endmodule

FILE: scope_edge_trigger_hysteresis.f
sv/seth_pkg.sv
sv/seth_cfg.sv
sv/seth_core.sv
sv/scope_edge_trigger_hysteresis.sv
verif/tb.sv
